@@ rtl/bounded_top_k_keeper_unit_assert.svh @@
// assertion macros used by the checker file
`ifndef BOUNDED_TOP_K_KEEPER_UNIT_ASSERT_SVH
`define BOUNDED_TOP_K_KEEPER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TKK_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("top-k keeper check failed");

// next-cycle implication, sampled on clk, off during reset
`define TKK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("top-k keeper check failed");

`endif

@@ rtl/tkk_pkg.sv @@
`default_nettype none
package tkk_pkg;

    // store size and derived widths
    localparam int CAPACITY    = 8;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int POS_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COORD_W     = 16;
    localparam int DIST_W      = 16;
    localparam int KIND_W      = 2;
    localparam int COUNT_OUT_W = 4;

    // transaction kinds; any other code is a plain query
    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH_REPL,
        ST_WAIT_REPL,
        ST_LAUNCH_REPORT,
        ST_WAIT_REPORT,
        ST_DONE
    } state_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic                      active;
        logic                      any;
        logic signed [COORD_W-1:0] best_x;
        logic signed [COORD_W-1:0] best_y;
        logic        [DIST_W-1:0]  best_dist;
        logic signed [COORD_W-1:0] worst_x;
        logic signed [COORD_W-1:0] worst_y;
        logic        [DIST_W-1:0]  worst_dist;
        logic        [POS_W-1:0]   worst_pos;
    } tkk_token_t;

    // entry write broadcast to the cells
    typedef struct packed {
        logic                      en;
        logic        [POS_W-1:0]   pos;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [DIST_W-1:0]  dist_val;
    } tkk_write_t;

endpackage
`default_nettype wire

@@ rtl/tkk_cell.sv @@
`default_nettype none
module tkk_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [tkk_pkg::POS_W-1:0] pos,
    input  wire logic                      occupied,
    input  wire tkk_pkg::tkk_write_t       wr,
    input  wire tkk_pkg::tkk_token_t       tok_in,
    output tkk_pkg::tkk_token_t            tok_out
);

    logic signed [tkk_pkg::COORD_W-1:0] x_reg;
    logic signed [tkk_pkg::COORD_W-1:0] y_reg;
    logic        [tkk_pkg::DIST_W-1:0]  dist_reg;
    tkk_pkg::tkk_token_t                tok_reg;
    tkk_pkg::tkk_token_t                tok_next;

    // entry storage, written when the broadcast targets this position
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.pos == pos))
        begin
            x_reg    <= wr.x;
            y_reg    <= wr.y;
            dist_reg <= wr.dist_val;
        end
    end

    // fold this entry into the passing token, first position wins ties
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && occupied)
        begin
            if (!tok_in.any)
            begin
                tok_next.any        = 1'b1;
                tok_next.best_x     = x_reg;
                tok_next.best_y     = y_reg;
                tok_next.best_dist  = dist_reg;
                tok_next.worst_x    = x_reg;
                tok_next.worst_y    = y_reg;
                tok_next.worst_dist = dist_reg;
                tok_next.worst_pos  = pos;
            end
            else
            begin
                if (dist_reg < tok_in.best_dist)
                begin
                    tok_next.best_x    = x_reg;
                    tok_next.best_y    = y_reg;
                    tok_next.best_dist = dist_reg;
                end
                if (dist_reg > tok_in.worst_dist)
                begin
                    tok_next.worst_x    = x_reg;
                    tok_next.worst_y    = y_reg;
                    tok_next.worst_dist = dist_reg;
                    tok_next.worst_pos  = pos;
                end
            end
        end
    end

    // token stage toward the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
`default_nettype wire

@@ rtl/bounded_top_k_keeper_unit.sv @@
// each transaction launches a scan token that walks the cell chain; the result is
//   registered once the token leaves the last cell; an insert into a full store runs
//   two scans (one to find the entry to replace, one to report)
// one transaction at a time: in_stall stays high until the result is queued, and
//   the next input is taken the cycle after the result is queued
// reset: rst_n clears the held count, sequencer and output valid; entries stay unwritten
`default_nettype none
module bounded_top_k_keeper_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [tkk_pkg::KIND_W-1:0]         kind,
    input  wire logic signed [tkk_pkg::COORD_W-1:0] cand_x,
    input  wire logic signed [tkk_pkg::COORD_W-1:0] cand_y,
    input  wire logic [tkk_pkg::DIST_W-1:0]         cand_dist,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [tkk_pkg::COUNT_OUT_W-1:0]         count,
    output logic                                    full_res,
    output logic                                    accepted,
    output logic signed [tkk_pkg::COORD_W-1:0]      best_x,
    output logic signed [tkk_pkg::COORD_W-1:0]      best_y,
    output logic [tkk_pkg::DIST_W-1:0]              best_dist,
    output logic signed [tkk_pkg::COORD_W-1:0]      worst_x,
    output logic signed [tkk_pkg::COORD_W-1:0]      worst_y,
    output logic [tkk_pkg::DIST_W-1:0]              worst_dist
);

    tkk_pkg::state_t                        state_reg;
    tkk_pkg::state_t                        state_next;
    logic [tkk_pkg::CNT_W-1:0]              count_reg;
    logic [tkk_pkg::CNT_W-1:0]              count_next;
    logic                                   acc_reg;
    logic                                   acc_next;
    tkk_pkg::tkk_token_t                    res_reg;
    tkk_pkg::tkk_token_t                    res_next;
    logic signed [tkk_pkg::COORD_W-1:0]     cand_x_reg;
    logic signed [tkk_pkg::COORD_W-1:0]     cand_y_reg;
    logic [tkk_pkg::DIST_W-1:0]             cand_dist_reg;
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic [tkk_pkg::COUNT_OUT_W-1:0]        count_out_reg;
    logic                                   full_reg;
    logic                                   accepted_reg;
    logic signed [tkk_pkg::COORD_W-1:0]     best_x_reg;
    logic signed [tkk_pkg::COORD_W-1:0]     best_y_reg;
    logic [tkk_pkg::DIST_W-1:0]             best_dist_reg;
    logic signed [tkk_pkg::COORD_W-1:0]     worst_x_reg;
    logic signed [tkk_pkg::COORD_W-1:0]     worst_y_reg;
    logic [tkk_pkg::DIST_W-1:0]             worst_dist_reg;
    logic [tkk_pkg::CNT_W+tkk_pkg::COUNT_OUT_W-1:0] count_wide;
    logic                                   in_fire;
    logic                                   out_load;
    logic                                   store_full;
    tkk_pkg::tkk_write_t                    wr;
    tkk_pkg::tkk_token_t                    tok [0:tkk_pkg::CAPACITY];
    tkk_pkg::tkk_token_t                    tok_last;

    assign in_stall   = (state_reg != tkk_pkg::ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign store_full = (count_reg == tkk_pkg::CNT_W'(tkk_pkg::CAPACITY));
    assign out_load   = (state_reg == tkk_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign tok_last   = tok[tkk_pkg::CAPACITY];

    // token launched into the head of the chain
    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = (state_reg == tkk_pkg::ST_LAUNCH_REPL) ||
                        (state_reg == tkk_pkg::ST_LAUNCH_REPORT);
    end

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < tkk_pkg::CAPACITY; gi++)
        begin : g_cell
            logic occ;
            assign occ = (count_reg > tkk_pkg::CNT_W'(gi));
            tkk_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .pos      (tkk_pkg::POS_W'(gi)),
                .occupied (occ),
                .wr       (wr),
                .tok_in   (tok[gi]),
                .tok_out  (tok[gi+1])
            );
        end
    endgenerate

    // sequencer, count update and entry writes
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        wr         = '0;
        case (state_reg)
            tkk_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    acc_next   = 1'b0;
                    state_next = tkk_pkg::ST_LAUNCH_REPORT;
                    if (kind == tkk_pkg::KIND_INSERT)
                    begin
                        if (store_full)
                        begin
                            state_next = tkk_pkg::ST_LAUNCH_REPL;
                        end
                        else
                        begin
                            // append at the first free position
                            wr.en       = 1'b1;
                            wr.pos      = count_reg[tkk_pkg::POS_W-1:0];
                            wr.x        = cand_x;
                            wr.y        = cand_y;
                            wr.dist_val = cand_dist;
                            count_next  = count_reg + tkk_pkg::CNT_W'(1);
                            acc_next    = 1'b1;
                        end
                    end
                    else if (kind == tkk_pkg::KIND_CLEAR)
                    begin
                        count_next = '0;
                    end
                end
            end
            tkk_pkg::ST_LAUNCH_REPL:
            begin
                state_next = tkk_pkg::ST_WAIT_REPL;
            end
            tkk_pkg::ST_WAIT_REPL:
            begin
                if (tok_last.active)
                begin
                    // replace the first largest entry on a strictly smaller distance
                    if (cand_dist_reg < tok_last.worst_dist)
                    begin
                        wr.en       = 1'b1;
                        wr.pos      = tok_last.worst_pos;
                        wr.x        = cand_x_reg;
                        wr.y        = cand_y_reg;
                        wr.dist_val = cand_dist_reg;
                        acc_next    = 1'b1;
                    end
                    state_next = tkk_pkg::ST_LAUNCH_REPORT;
                end
            end
            tkk_pkg::ST_LAUNCH_REPORT:
            begin
                state_next = tkk_pkg::ST_WAIT_REPORT;
            end
            tkk_pkg::ST_WAIT_REPORT:
            begin
                if (tok_last.active)
                begin
                    res_next   = tok_last;
                    state_next = tkk_pkg::ST_DONE;
                end
            end
            tkk_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = tkk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tkk_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tkk_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction payload and scan result holding
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        res_reg <= res_next;
        if (in_fire)
        begin
            cand_x_reg    <= cand_x;
            cand_y_reg    <= cand_y;
            cand_dist_reg <= cand_dist;
        end
    end

    // output register
    assign out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    assign count_wide     = {{tkk_pkg::COUNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            count_out_reg  <= count_wide[tkk_pkg::COUNT_OUT_W-1:0];
            full_reg       <= store_full;
            accepted_reg   <= acc_reg;
            best_x_reg     <= res_reg.best_x;
            best_y_reg     <= res_reg.best_y;
            best_dist_reg  <= res_reg.best_dist;
            worst_x_reg    <= res_reg.worst_x;
            worst_y_reg    <= res_reg.worst_y;
            worst_dist_reg <= res_reg.worst_dist;
        end
    end

    assign out_valid  = out_valid_reg;
    assign count      = count_out_reg;
    assign full_res   = full_reg;
    assign accepted   = accepted_reg;
    assign best_x     = best_x_reg;
    assign best_y     = best_y_reg;
    assign best_dist  = best_dist_reg;
    assign worst_x    = worst_x_reg;
    assign worst_y    = worst_y_reg;
    assign worst_dist = worst_dist_reg;

endmodule
`default_nettype wire

@@ rtl/tkk_checker.sv @@
`default_nettype none
`include "bounded_top_k_keeper_unit_assert.svh"
module tkk_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_stall,
    input wire logic [tkk_pkg::KIND_W-1:0]         kind,
    input wire logic signed [tkk_pkg::COORD_W-1:0] cand_x,
    input wire logic signed [tkk_pkg::COORD_W-1:0] cand_y,
    input wire logic [tkk_pkg::DIST_W-1:0]         cand_dist,
    input wire logic                               out_valid,
    input wire logic                               out_stall,
    input wire logic [tkk_pkg::COUNT_OUT_W-1:0]    count,
    input wire logic                               full_res,
    input wire logic                               accepted,
    input wire logic signed [tkk_pkg::COORD_W-1:0] best_x,
    input wire logic signed [tkk_pkg::COORD_W-1:0] best_y,
    input wire logic [tkk_pkg::DIST_W-1:0]         best_dist,
    input wire logic signed [tkk_pkg::COORD_W-1:0] worst_x,
    input wire logic signed [tkk_pkg::COORD_W-1:0] worst_y,
    input wire logic [tkk_pkg::DIST_W-1:0]         worst_dist
);

    // a stalled result holds
    `TKK_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(count) && $stable(best_dist) && $stable(worst_dist))

    // one transaction in flight: input is busy right after an accept
    `TKK_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // best never ranks above worst
    `TKK_ASSERT_NOW(a_best_le_worst, out_valid, best_dist <= worst_dist)

    // an empty store reports all zeros
    `TKK_ASSERT_NOW(a_empty_zero, out_valid && (count == '0) && !full_res,
        (best_x == '0) && (best_y == '0) && (best_dist == '0) &&
        (worst_x == '0) && (worst_y == '0) && (worst_dist == '0) && !accepted)

endmodule

bind bounded_top_k_keeper_unit tkk_checker u_tkk_checker (.*);
`default_nettype wire

@@ test/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // spare kind code, handled by the block as a plain query
    localparam logic [tkk_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    localparam int ITEM_TOTAL       = 550;
    localparam int DRAIN_AT         = 300;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTED     = 10;

    typedef struct {
        logic [tkk_pkg::KIND_W-1:0]         op;
        logic signed [tkk_pkg::COORD_W-1:0] x;
        logic signed [tkk_pkg::COORD_W-1:0] y;
        logic [tkk_pkg::DIST_W-1:0]         dist_val;
        bit                                 drain;
    } cand_item_t;

    typedef struct packed {
        logic [tkk_pkg::COUNT_OUT_W-1:0]    count;
        logic                               full;
        logic                               taken;
        logic signed [tkk_pkg::COORD_W-1:0] best_x;
        logic signed [tkk_pkg::COORD_W-1:0] best_y;
        logic [tkk_pkg::DIST_W-1:0]         best_dist;
        logic signed [tkk_pkg::COORD_W-1:0] worst_x;
        logic signed [tkk_pkg::COORD_W-1:0] worst_y;
        logic [tkk_pkg::DIST_W-1:0]         worst_dist;
    } keeper_report_t;

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic [tkk_pkg::KIND_W-1:0]         kind = tkk_pkg::KIND_QUERY;
    logic signed [tkk_pkg::COORD_W-1:0] cand_x = '0;
    logic signed [tkk_pkg::COORD_W-1:0] cand_y = '0;
    logic [tkk_pkg::DIST_W-1:0]         cand_dist = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b1;
    logic [tkk_pkg::COUNT_OUT_W-1:0]    count;
    logic                               full_res;
    logic                               accepted;
    logic signed [tkk_pkg::COORD_W-1:0] best_x;
    logic signed [tkk_pkg::COORD_W-1:0] best_y;
    logic [tkk_pkg::DIST_W-1:0]         best_dist;
    logic signed [tkk_pkg::COORD_W-1:0] worst_x;
    logic signed [tkk_pkg::COORD_W-1:0] worst_y;
    logic [tkk_pkg::DIST_W-1:0]         worst_dist;

    cand_item_t     pending_items[$];
    keeper_report_t expected_reports[$];

    int items_sent     = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int send_pause     = 0;
    int stall_left     = 0;
    bit send_quiet     = 1'b0;
    bit recv_quiet     = 1'b0;
    bit long_hold_done = 1'b0;

    // shadow copy of the candidate store
    logic [tkk_pkg::COORD_W-1:0] keep_x    [tkk_pkg::CAPACITY];
    logic [tkk_pkg::COORD_W-1:0] keep_y    [tkk_pkg::CAPACITY];
    logic [tkk_pkg::DIST_W-1:0]  keep_dist [tkk_pkg::CAPACITY];
    int                          keep_held = 0;

    bounded_top_k_keeper_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .cand_x     (cand_x),
        .cand_y     (cand_y),
        .cand_dist  (cand_dist),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .count      (count),
        .full_res   (full_res),
        .accepted   (accepted),
        .best_x     (best_x),
        .best_y     (best_y),
        .best_dist  (best_dist),
        .worst_x    (worst_x),
        .worst_y    (worst_y),
        .worst_dist (worst_dist)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // first held position with the largest distance
    function automatic int first_largest_pos();
        int pos;
        pos = 0;
        for (int i = 1; i < keep_held; i++)
        begin
            if (keep_dist[i] > keep_dist[pos])
                pos = i;
        end
        return pos;
    endfunction

    // first held position with the smallest distance
    function automatic int first_smallest_pos();
        int pos;
        pos = 0;
        for (int i = 1; i < keep_held; i++)
        begin
            if (keep_dist[i] < keep_dist[pos])
                pos = i;
        end
        return pos;
    endfunction

    // apply one transaction to the shadow store and build its report
    function automatic keeper_report_t keeper_step(logic [tkk_pkg::KIND_W-1:0] op,
                                                   logic [tkk_pkg::COORD_W-1:0] x,
                                                   logic [tkk_pkg::COORD_W-1:0] y,
                                                   logic [tkk_pkg::DIST_W-1:0] d);
        keeper_report_t r;
        int             hi;
        int             lo;
        r = '0;
        if (op == tkk_pkg::KIND_INSERT)
        begin
            if (keep_held < tkk_pkg::CAPACITY)
            begin
                keep_x[keep_held]    = x;
                keep_y[keep_held]    = y;
                keep_dist[keep_held] = d;
                keep_held++;
                r.taken = 1'b1;
            end
            else
            begin
                hi = first_largest_pos();
                if (d < keep_dist[hi])
                begin
                    keep_x[hi]    = x;
                    keep_y[hi]    = y;
                    keep_dist[hi] = d;
                    r.taken = 1'b1;
                end
            end
        end
        else if (op == tkk_pkg::KIND_CLEAR)
        begin
            keep_held = 0;
        end
        r.count = keep_held[tkk_pkg::COUNT_OUT_W-1:0];
        r.full  = (keep_held == tkk_pkg::CAPACITY);
        if (keep_held != 0)
        begin
            lo = first_smallest_pos();
            hi = first_largest_pos();
            r.best_x     = keep_x[lo];
            r.best_y     = keep_y[lo];
            r.best_dist  = keep_dist[lo];
            r.worst_x    = keep_x[hi];
            r.worst_y    = keep_y[hi];
            r.worst_dist = keep_dist[hi];
        end
        return r;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_pause(bit quiet);
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    // distance drawn from a narrow, middle or full span, with extremes mixed in
    function automatic logic [tkk_pkg::DIST_W-1:0] pick_dist(int span);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 1) ? {tkk_pkg::DIST_W{1'b1}} : '0;
        case (span)
            0:       return tkk_pkg::DIST_W'($urandom_range(0, 15));
            1:       return tkk_pkg::DIST_W'($urandom_range(0, 255));
            default: return rand16();
        endcase
    endfunction

    task automatic add_item(logic [tkk_pkg::KIND_W-1:0] op, logic [15:0] x, logic [15:0] y,
                            logic [15:0] d, bit drain);
        cand_item_t it;
        it.op       = op;
        it.x        = x;
        it.y        = y;
        it.dist_val = d;
        it.drain    = drain || (pending_items.size() == DRAIN_AT) ||
                      ($urandom_range(0, 149) == 0);
        pending_items.push_back(it);
    endtask

    task automatic bump_mismatch(string msg);
        if (mismatch_count < MAX_REPORTED)
            $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
            bump_mismatch($sformatf("%s expected %h got %h", name, want, got));
    endtask

    // driver: offers queued transactions, with random gaps
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit         took;
        int         pause_n;
        cand_item_t it;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            send_pause <= 0;
        end
        else
        begin
            took    = in_valid && !in_stall;
            pause_n = send_pause;
            if (took)
            begin
                expected_reports.push_back(keeper_step(kind, cand_x, cand_y, cand_dist));
                items_sent <= items_sent + 1;
                pause_n = pick_pause(send_quiet);
                if ($urandom_range(0, 39) == 0)
                    send_quiet <= !send_quiet;
            end
            if (in_valid && !took)
            begin
                // stalled transaction holds
            end
            else if (pause_n > 0)
            begin
                pause_n--;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain || items_sent + took == results_seen))
            begin
                it = pending_items.pop_front();
                kind      <= it.op;
                cand_x    <= it.x;
                cand_y    <= it.y;
                cand_dist <= it.dist_val;
                in_valid  <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
            send_pause <= pause_n;
        end
    end

    // receiver back-pressure, including one long hold-off
    always @(posedge clk or negedge rst_n)
    begin : receiver_stall
        int left_n;
        if (!rst_n)
        begin
            out_stall  <= 1'b1;
            stall_left <= 0;
        end
        else
        begin
            left_n = stall_left;
            if (!long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                left_n = LONG_HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end
            else if (left_n == 0)
            begin
                left_n = pick_pause(recv_quiet);
                if ($urandom_range(0, 199) == 0)
                    recv_quiet <= !recv_quiet;
            end
            if (left_n > 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= left_n - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= 0;
            end
        end
    end

    // monitor: compares each result transaction with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : monitor
        keeper_report_t want;
        if (!rst_n)
        begin
            results_seen <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_reports.size() == 0)
            begin
                bump_mismatch("result with no transaction outstanding");
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("count", 16'(want.count), 16'(count));
                check_field("full_res", 16'(want.full), 16'(full_res));
                check_field("accepted", 16'(want.taken), 16'(accepted));
                check_field("best_x", want.best_x, best_x);
                check_field("best_y", want.best_y, best_y);
                check_field("best_dist", want.best_dist, best_dist);
                check_field("worst_x", want.worst_x, worst_x);
                check_field("worst_y", want.worst_y, worst_y);
                check_field("worst_dist", want.worst_dist, worst_dist);
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin : run_control
        int span;
        int run_len;

        // empty store, clear on empty, extremes of coordinates and distance
        add_item(tkk_pkg::KIND_QUERY, rand16(), rand16(), rand16(), 1'b0);
        add_item(tkk_pkg::KIND_CLEAR, rand16(), rand16(), rand16(), 1'b0);
        add_item(tkk_pkg::KIND_INSERT, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, 16'h7FFF, 16'h8000, 16'h0000, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd500, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd500, 1'b0);
        // ties on both the largest and the smallest distance
        add_item(tkk_pkg::KIND_INSERT, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
        add_item(KIND_SPARE, rand16(), rand16(), rand16(), 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd7, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd9, 1'b0);
        // full store: equal distance dropped, smaller replaces first largest
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'hFFFF, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd1, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd2, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd600, 1'b0);
        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(), 16'd499, 1'b0);
        add_item(tkk_pkg::KIND_QUERY, rand16(), rand16(), rand16(), 1'b0);
        add_item(tkk_pkg::KIND_CLEAR, rand16(), rand16(), rand16(), 1'b1);
        add_item(tkk_pkg::KIND_QUERY, rand16(), rand16(), rand16(), 1'b0);
        add_item(tkk_pkg::KIND_INSERT, 16'h0000, 16'h0000, 16'h0000, 1'b0);

        // random part: mostly clear-then-fill runs, some noise
        while (pending_items.size() < ITEM_TOTAL)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                span    = $urandom_range(0, 2);
                run_len = $urandom_range(0, 20);
                add_item(tkk_pkg::KIND_CLEAR, rand16(), rand16(), rand16(), 1'b0);
                for (int i = 0; i < run_len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        add_item($urandom_range(0, 1) ? tkk_pkg::KIND_QUERY : KIND_SPARE,
                                 rand16(), rand16(), rand16(), 1'b0);
                    else
                        add_item(tkk_pkg::KIND_INSERT, rand16(), rand16(),
                                 pick_dist(span), 1'b0);
                end
            end
            else
            begin
                add_item(tkk_pkg::KIND_W'($urandom_range(0, 3)),
                         rand16(), rand16(), rand16(), 1'b0);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (2 * tkk_pkg::CAPACITY + 8) @(posedge clk);

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("[bounded_top_k_keeper_unit] OK");
        else
            $display("[bounded_top_k_keeper_unit] ERROR");
        $finish;
    end

    // overall time limit
    initial
    begin
        #5ms;
        $display("[bounded_top_k_keeper_unit] ERROR");
        $finish;
    end

endmodule
